/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the blur block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define RBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is also checked during reset.
`define RBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hdl/rbb_pkg.sv */
// Types, constants and small helper functions of the region box blur block.
// No dependencies; compiled before every other file of the block.
package rbb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COLSUM_W   = SAMPLE_W + 2;
    localparam int SUM_W      = SAMPLE_W + 4;
    localparam int MAG_W      = SAMPLE_W + 3;
    localparam int QUOT_W     = SAMPLE_W + 1;
    localparam int RECIP_W    = 22;
    localparam int DIV_SHIFT  = 23;
    localparam int PROD_W     = MAG_W + RECIP_W;

    localparam int ROWS_W     = 7;
    localparam int COLS_W     = 7;
    localparam int REGION_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [ROWS_W-1:0]   NUM_ROWS_RST      = ROWS_W'(64);
    localparam logic [COLS_W-1:0]   NUM_COLS_RST      = COLS_W'(64);
    localparam logic [REGION_W-1:0] REGION_TOP_RST    = REGION_W'(0);
    localparam logic [REGION_W-1:0] REGION_LEFT_RST   = REGION_W'(0);
    localparam logic [REGION_W-1:0] REGION_BOTTOM_RST = REGION_W'(63);
    localparam logic [REGION_W-1:0] REGION_RIGHT_RST  = REGION_W'(63);

    // Rounded-up reciprocals scaled by 2**DIV_SHIFT. The error term of each is at most 4,
    // which keeps the truncated product exact for magnitudes below 2**21.
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(1 << (DIV_SHIFT - 2));
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << DIV_SHIFT) + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << DIV_SHIFT) + 8) / 9);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COLSUM_W-1:0] t_colsum;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic        [MAG_W-1:0]    t_mag;
    typedef logic        [RECIP_W-1:0]  t_recip;

    typedef enum logic [0:0] {
        OP_ELEM  = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS,
        REG_NUM_COLS,
        REG_REGION_TOP,
        REG_REGION_LEFT,
        REG_REGION_BOTTOM,
        REG_REGION_RIGHT
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

    function automatic t_recip div_recip(input t_div d);
        t_recip r;
        case (d)
            DIV_4:   r = RECIP_4;
            DIV_6:   r = RECIP_6;
            DIV_9:   r = RECIP_9;
            default: r = RECIP_6;
        endcase
        return r;
    endfunction

    // Half the divisor, added to the magnitude so the floor rounds to nearest.
    function automatic t_mag div_half(input t_div d);
        t_mag h;
        case (d)
            DIV_4:   h = MAG_W'(2);
            DIV_6:   h = MAG_W'(3);
            DIV_9:   h = MAG_W'(4);
            default: h = MAG_W'(3);
        endcase
        return h;
    endfunction

endpackage

/* hdl/rbb_ifs.sv */
// Valid/ready channel interfaces of the region box blur block: input, result, config.
// Depends on rbb_pkg.
interface rbb_in_if;
    import rbb_pkg::*;
    logic      valid;
    logic      ready;
    t_opcode   opcode;
    t_sample   sample;
    modport source (output valid, opcode, sample, input ready);
    modport sink   (input valid, opcode, sample, output ready);
endinterface

interface rbb_out_if;
    import rbb_pkg::*;
    logic      valid;
    logic      ready;
    t_sample   value;
    logic      last;
    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface rbb_cfg_if;
    import rbb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/region_box_blur_3x3.sv */
// Streaming 3x3 mean filter restricted to a configurable rectangle.
// Depends on rbb_pkg and the channel interfaces in rbb_ifs.sv.
//
//   Channel  Role    Payload          Transfer at
//   i_in     sink    opcode, sample   valid and ready high
//   o_out    source  value, last      valid and ready high
//   i_cfg    sink    index, data      valid high (ready is always high)
//
// The block takes one input transfer per clock, sustained while o_out does not stall.
// A result reaches the output register through the window, sum, multiply and quotient
// stages; the line stores add one row plus one element of buffering on top.
// The rate is set by the line store banks, each read and written at most once per cycle.
// Reset clears counters, configuration and pipeline valids; the line stores are
// not cleared, since no entry is used before the current matrix has written it.
// While o_out stalls the result stays put and the stages behind it keep filling;
// i_in.ready drops only once the window stage has a result with nowhere to go.
module region_box_blur_3x3 #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbb_in_if.sink    i_in,
    rbb_out_if.source o_out,
    rbb_cfg_if.sink   i_cfg
);
    import rbb_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int NCOL_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 2);

    // One result: which neighbour rows and columns lie in the matrix, region hit, last.
    typedef struct packed {
        logic use_up;
        logic use_low;
        logic use_left;
        logic use_right;
        logic in_region;
        logic last;
    } t_pos;

    // Configuration registers.
    logic [ROWS_W-1:0]   r_num_rows;
    logic [COLS_W-1:0]   r_num_cols;
    logic [REGION_W-1:0] r_top;
    logic [REGION_W-1:0] r_left;
    logic [REGION_W-1:0] r_bottom;
    logic [REGION_W-1:0] r_right;
    logic                cfg_hit;

    // Effective matrix size and the input position counters.
    logic [ROW_W-1:0]  rows_eff;
    logic [NCOL_W-1:0] cols_eff;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;

    // Accept stage.
    logic              is_flush;
    logic              take;
    logic              in_acc;
    logic              have_edge;
    logic              have_mid;
    logic [ROW_W-1:0]  a_er;
    logic [COL_W-1:0]  a_ec;
    t_pos              a_pos;

    // Line stores: two banks that trade the upper and middle roles every row.
    t_sample r_bank0 [MAX_COLS];
    t_sample r_bank1 [MAX_COLS];
    t_sample r_rd0;
    t_sample r_rd1;

    // Window stage.
    logic    r_b_vld;
    logic    r_b_have;
    logic    r_b_par;
    t_sample r_b_low;
    t_pos    r_b_pos;
    t_sample r_win [3][3];
    t_sample b_up;
    t_sample b_mid;
    t_colsum b_sl;
    t_colsum b_sc;
    t_colsum b_sr;
    t_div    b_div;
    logic    b_adv;
    logic    b_free;

    // Sum stage.
    logic    r_c_vld;
    t_colsum r_c_sl;
    t_colsum r_c_sc;
    t_colsum r_c_sr;
    t_div    r_c_div;
    t_sample r_c_centre;
    logic    r_c_inreg;
    logic    r_c_last;
    t_sum    c_sum;
    t_sum    c_abs;
    logic    c_neg;
    t_mag    c_mag;
    logic    c_free;

    // Multiply stage.
    logic    r_d_vld;
    t_mag    r_d_mag;
    t_recip  r_d_recip;
    logic    r_d_neg;
    t_sample r_d_centre;
    logic    r_d_inreg;
    logic    r_d_last;
    logic    d_free;

    // Quotient stage.
    logic              r_e_vld;
    logic [PROD_W-1:0] r_e_prod;
    logic              r_e_neg;
    t_sample           r_e_centre;
    logic              r_e_inreg;
    logic              r_e_last;
    logic [QUOT_W-1:0] e_quot;
    logic [QUOT_W-1:0] e_signed;
    t_sample           e_value;
    logic              e_free;

    // Output register.
    logic    r_o_vld;
    t_sample r_o_value;
    logic    r_o_last;
    logic    o_free;

    function automatic t_colsum col_sum(input t_sample up, input t_sample mid,
                                        input t_sample low, input logic use_up,
                                        input logic use_low);
        t_colsum acc;
        acc = t_colsum'(mid);
        if (use_up) begin
            acc = acc + t_colsum'(up);
        end
        if (use_low) begin
            acc = acc + t_colsum'(low);
        end
        return acc;
    endfunction

    // ------------------------------------------------------------------
    // Configuration. Any write to a known register restarts the matrix.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_hit     = i_cfg.valid && (i_cfg.index <= REG_REGION_RIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NUM_ROWS_RST;
            r_num_cols <= NUM_COLS_RST;
            r_top      <= REGION_TOP_RST;
            r_left     <= REGION_LEFT_RST;
            r_bottom   <= REGION_BOTTOM_RST;
            r_right    <= REGION_RIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_NUM_ROWS:      r_num_rows <= i_cfg.data[ROWS_W-1:0];
                REG_NUM_COLS:      r_num_cols <= i_cfg.data[COLS_W-1:0];
                REG_REGION_TOP:    r_top      <= i_cfg.data[REGION_W-1:0];
                REG_REGION_LEFT:   r_left     <= i_cfg.data[REGION_W-1:0];
                REG_REGION_BOTTOM: r_bottom   <= i_cfg.data[REGION_W-1:0];
                REG_REGION_RIGHT:  r_right    <= i_cfg.data[REGION_W-1:0];
                default: ;
            endcase
        end
    end

    // The matrix size is clamped to at least two and at most MAX_ROWS by MAX_COLS.
    always_comb begin
        if (r_num_rows < ROWS_W'(2)) begin
            rows_eff = ROW_W'(2);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = ROW_W'(r_num_rows);
        end
        if (r_num_cols < COLS_W'(2)) begin
            cols_eff = NCOL_W'(2);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_eff = NCOL_W'(MAX_COLS);
        end else begin
            cols_eff = NCOL_W'(r_num_cols);
        end
    end

    // ------------------------------------------------------------------
    // Accept stage. Elements are taken while rows remain; flush ticks only
    // once every row is in. Anything else is consumed without effect.
    // ------------------------------------------------------------------
    assign is_flush  = (i_in.opcode == OP_FLUSH);
    assign take      = is_flush ? (r_row >= rows_eff) : (r_row < rows_eff);
    assign in_acc    = i_in.valid && b_free && take;
    assign i_in.ready = b_free;

    // A column start from row 2 on finishes the right-edge element two rows up; a
    // position past row 0 and column 0 finishes the element one row up and one column left.
    assign have_edge = (r_col == '0) && (r_row >= ROW_W'(2));
    assign have_mid  = (r_col != '0) && (r_row != '0);

    always_comb begin
        a_er = have_edge ? ROW_W'(r_row - ROW_W'(2)) : ROW_W'(r_row - ROW_W'(1));
        a_ec = have_edge ? COL_W'(cols_eff - NCOL_W'(1)) : COL_W'(r_col - COL_W'(1));
        a_pos.use_up    = (a_er != '0);
        a_pos.use_low   = (32'(a_er) + 32'd1) < 32'(rows_eff);
        a_pos.use_left  = (a_ec != '0);
        a_pos.use_right = !have_edge;
        a_pos.in_region = (32'(a_er) >= 32'(r_top))  && (32'(a_er) <= 32'(r_bottom)) &&
                          (32'(a_ec) >= 32'(r_left)) && (32'(a_ec) <= 32'(r_right));
        // The flush tick one row past the end finishes the final element.
        a_pos.last      = is_flush && (32'(r_row) == 32'(rows_eff) + 32'd1);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (a_pos.last) begin
            n_row = '0;
            n_col = '0;
        end else if (r_col == COL_W'(cols_eff - NCOL_W'(1))) begin
            n_col = '0;
            n_row = ROW_W'(r_row + ROW_W'(1));
        end else begin
            n_col = COL_W'(r_col + COL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_hit) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. Row r writes its elements into bank r[0], which held row
    // r-2; the read in the same cycle still returns row r-2 as the upper row.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd0 <= r_bank0[r_col];
            if (!is_flush && !r_row[0]) begin
                r_bank0[r_col] <= i_in.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd1 <= r_bank1[r_col];
            if (!is_flush && r_row[0]) begin
                r_bank1[r_col] <= i_in.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_par  <= r_row[0];
            r_b_low  <= is_flush ? t_sample'(0) : i_in.sample;
            r_b_have <= have_edge || have_mid;
            r_b_pos  <= a_pos;
        end
    end

    // ------------------------------------------------------------------
    // Window stage. Column 2 of the window holds the centre column; the new
    // column from the stores is the right neighbor. Items that finish no
    // element only shift the window.
    // ------------------------------------------------------------------
    assign b_up  = r_b_par ? r_rd1 : r_rd0;
    assign b_mid = r_b_par ? r_rd0 : r_rd1;

    always_comb begin
        b_sl = r_b_pos.use_left ?
               col_sum(r_win[1][0], r_win[1][1], r_win[1][2],
                       r_b_pos.use_up, r_b_pos.use_low) : t_colsum'(0);
        b_sc = col_sum(r_win[2][0], r_win[2][1], r_win[2][2],
                       r_b_pos.use_up, r_b_pos.use_low);
        b_sr = r_b_pos.use_right ?
               col_sum(b_up, b_mid, r_b_low, r_b_pos.use_up, r_b_pos.use_low) :
               t_colsum'(0);
        if (r_b_pos.use_left && r_b_pos.use_right && r_b_pos.use_up && r_b_pos.use_low) begin
            b_div = DIV_9;
        end else if (!(r_b_pos.use_left && r_b_pos.use_right) &&
                     !(r_b_pos.use_up && r_b_pos.use_low)) begin
            b_div = DIV_4;
        end else begin
            b_div = DIV_6;
        end
    end

    assign b_adv  = r_b_vld && (!r_b_have || c_free);
    assign b_free = !r_b_vld || b_adv;

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= b_up;
            r_win[2][1] <= b_mid;
            r_win[2][2] <= r_b_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free) begin
            r_c_sl     <= b_sl;
            r_c_sc     <= b_sc;
            r_c_sr     <= b_sr;
            r_c_div    <= b_div;
            r_c_centre <= r_win[2][1];
            r_c_inreg  <= r_b_pos.in_region;
            r_c_last   <= r_b_pos.last;
        end
    end

    // ------------------------------------------------------------------
    // Sum stage: total, magnitude and rounding offset (ties away from zero).
    // ------------------------------------------------------------------
    always_comb begin
        c_sum = t_sum'(r_c_sl) + t_sum'(r_c_sc) + t_sum'(r_c_sr);
        c_neg = c_sum[SUM_W-1];
        c_abs = c_neg ? t_sum'(-c_sum) : c_sum;
        c_mag = t_mag'(c_abs[MAG_W-1:0] + div_half(r_c_div));
    end

    assign c_free = !r_c_vld || d_free;

    always_ff @(posedge i_clk) begin
        if (d_free) begin
            r_d_mag    <= c_mag;
            r_d_recip  <= div_recip(r_c_div);
            r_d_neg    <= c_neg;
            r_d_centre <= r_c_centre;
            r_d_inreg  <= r_c_inreg;
            r_d_last   <= r_c_last;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: division by 4, 6 or 9 as a reciprocal product.
    // ------------------------------------------------------------------
    assign d_free = !r_d_vld || e_free;

    always_ff @(posedge i_clk) begin
        if (e_free) begin
            r_e_prod   <= PROD_W'(r_d_mag) * PROD_W'(r_d_recip);
            r_e_neg    <= r_d_neg;
            r_e_centre <= r_d_centre;
            r_e_inreg  <= r_d_inreg;
            r_e_last   <= r_d_last;
        end
    end

    // ------------------------------------------------------------------
    // Quotient stage: restore the sign, or pass the centre element through.
    // ------------------------------------------------------------------
    always_comb begin
        e_quot   = r_e_prod[DIV_SHIFT +: QUOT_W];
        e_signed = r_e_neg ? QUOT_W'(~e_quot + QUOT_W'(1)) : e_quot;
        e_value  = r_e_inreg ? t_sample'(e_signed[SAMPLE_W-1:0]) : r_e_centre;
    end

    assign e_free = !r_e_vld || o_free;
    assign o_free = !r_o_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_o_value <= e_value;
            r_o_last  <= r_e_last;
        end
    end

    // Stage valids: each stage loads when the stage after it can take its item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_vld <= i_in.valid && take;
            end
            if (c_free) begin
                r_c_vld <= r_b_vld && r_b_have;
            end
            if (d_free) begin
                r_d_vld <= r_c_vld;
            end
            if (e_free) begin
                r_e_vld <= r_d_vld;
            end
            if (o_free) begin
                r_o_vld <= r_e_vld;
            end
        end
    end

    assign o_out.valid = r_o_vld;
    assign o_out.value = r_o_value;
    assign o_out.last  = r_o_last;

endmodule

/* hdl/rbb_checker.sv */
// Port-level assertions for region_box_blur_3x3, attached by the bind at the end.
// Depends on rbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rbb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [rbb_pkg::SAMPLE_W-1:0] i_out_value,
    input logic                         i_out_last
);
    import rbb_pkg::*;

    // A stalled result holds its payload until it is transferred.
    `RBB_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_last), "stalled result changed")

    // With the output register empty, every stage behind it can move, so input is open.
    `RBB_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input blocked with empty output register")

    // Reset leaves no result behind.
    `RBB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

endmodule

bind region_box_blur_3x3 rbb_checker u_rbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last)
);

/* test/rbb_blur_checker.sv */
// Scoreboard for the region box blur: tracks matrix state, predicts each pixel and compares.
// Depends on rbb_pkg and the channel interfaces in rbb_ifs.sv; it only watches the channels.
module rbb_blur_checker #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rbb_in_if    in_mon,
    rbb_out_if   out_mon,
    rbb_cfg_if   cfg_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbb_pkg::*;

    typedef struct packed {
        t_sample value;
        logic    last;
    } t_blur_px;

    logic [ROWS_W-1:0]   rows_reg;
    logic [COLS_W-1:0]   cols_reg;
    logic [REGION_W-1:0] top_reg, left_reg, bottom_reg, right_reg;

    t_sample upper_line [MAX_COLS];
    t_sample middle_line [MAX_COLS];
    // Window columns run oldest to newest, rows upper, middle, lower.
    t_sample win [3][3];
    int      row_ptr, col_ptr, emit_cnt;

    t_blur_px awaited_px [$];
    int       fail_cnt, checked_cnt;

    function automatic int clamp_dim(input int raw, input int hi);
        return (raw < 2) ? 2 : (raw > hi) ? hi : raw;
    endfunction

    function automatic void restart_matrix();
        row_ptr  = 0;
        col_ptr  = 0;
        emit_cnt = 0;
    endfunction

    function automatic void reset_model();
        int k;
        rows_reg   = NUM_ROWS_RST;
        cols_reg   = NUM_COLS_RST;
        top_reg    = REGION_TOP_RST;
        left_reg   = REGION_LEFT_RST;
        bottom_reg = REGION_BOTTOM_RST;
        right_reg  = REGION_RIGHT_RST;
        for (k = 0; k < MAX_COLS; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (k = 0; k < 9; k++) begin
            win[k / 3][k % 3] = '0;
        end
        restart_matrix();
    endfunction

    // Writes to indexes past the last register are ignored and do not restart.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_reg'(idx))
            REG_NUM_ROWS:      rows_reg   = data[ROWS_W-1:0];
            REG_NUM_COLS:      cols_reg   = data[COLS_W-1:0];
            REG_REGION_TOP:    top_reg    = data[REGION_W-1:0];
            REG_REGION_LEFT:   left_reg   = data[REGION_W-1:0];
            REG_REGION_BOTTOM: bottom_reg = data[REGION_W-1:0];
            REG_REGION_RIGHT:  right_reg  = data[REGION_W-1:0];
            default:           return;
        endcase
        restart_matrix();
    endfunction

    // Mean of the in-matrix neighbours of pixel (er, ec), centred on window column ccol.
    function automatic t_sample window_mean(input int ccol, input int er, input int ec,
                                            input int nr, input int nc);
        int sum, n, dc, dr, wc;
        if (!(er >= int'(top_reg) && er <= int'(bottom_reg) &&
              ec >= int'(left_reg) && ec <= int'(right_reg)))
            return win[ccol][1];
        sum = 0;
        n   = 0;
        for (dc = -1; dc <= 1; dc++) begin
            wc = ccol + dc;
            if (ec + dc < 0 || ec + dc >= nc || wc < 0 || wc > 2)
                continue;
            for (dr = -1; dr <= 1; dr++) begin
                if (er + dr < 0 || er + dr >= nr)
                    continue;
                sum += int'(win[wc][dr + 1]);
                n++;
            end
        end
        if (n == 0)
            return win[ccol][1];
        if (sum >= 0)
            return t_sample'((sum + n / 2) / n);
        return t_sample'(-((-sum + n / 2) / n));
    endfunction

    function automatic void blur_step(input t_opcode op, input t_sample smp);
        int       nr, nc, total, ir, ic, k;
        bit       have;
        t_sample  res, s;
        t_blur_px px;
        nr    = clamp_dim(int'(rows_reg), MAX_ROWS);
        nc    = clamp_dim(int'(cols_reg), MAX_COLS);
        total = nr * nc;
        have  = 1'b0;
        res   = '0;
        s     = '0;
        if (op == OP_ELEM) begin
            if (row_ptr >= nr)
                return;
            s = smp;
        end else if (row_ptr < nr || emit_cnt >= total) begin
            return;
        end
        ir = row_ptr;
        ic = col_ptr % nc;
        // A new row finishes the right-edge pixel two rows up.
        if (ic == 0 && ir >= 2) begin
            res  = window_mean(2, ir - 2, nc - 1, nr, nc);
            have = 1'b1;
        end
        for (k = 0; k < 3; k++) begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
        end
        win[2][0] = upper_line[ic];
        win[2][1] = middle_line[ic];
        win[2][2] = s;
        if (op == OP_ELEM) begin
            upper_line[ic]  = middle_line[ic];
            middle_line[ic] = s;
        end
        if (ic >= 1 && ir >= 1) begin
            res  = window_mean(1, ir - 1, ic - 1, nr, nc);
            have = 1'b1;
        end
        ic++;
        if (ic >= nc) begin
            ic = 0;
            ir++;
        end
        row_ptr = ir;
        col_ptr = ic;
        if (have) begin
            emit_cnt++;
            px.value = res;
            px.last  = (emit_cnt >= total);
            awaited_px.push_back(px);
            if (px.last)
                restart_matrix();
        end
    endfunction

    function automatic void check_pixel(input t_sample value, input logic last);
        t_blur_px want;
        if (awaited_px.size() == 0) begin
            fail_cnt++;
            $display("%0t ns: result with nothing expected, expected none, actual value %0d last %0b",
                     $time, value, last);
            return;
        end
        want = awaited_px.pop_front();
        checked_cnt++;
        if (value !== want.value) begin
            fail_cnt++;
            $display("%0t ns: value mismatch, expected %0d, actual %0d",
                     $time, want.value, value);
        end
        if (last !== want.last) begin
            fail_cnt++;
            $display("%0t ns: last flag mismatch, expected %0b, actual %0b",
                     $time, want.last, last);
        end
    endfunction

    initial reset_model();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            awaited_px.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready)
                apply_reg_write(cfg_mon.index, cfg_mon.data);
            if (in_mon.valid && in_mon.ready)
                blur_step(in_mon.opcode, in_mon.sample);
            if (out_mon.valid && out_mon.ready)
                check_pixel(out_mon.value, out_mon.last);
        end
        o_fail_count <= fail_cnt;
        o_pending    <= awaited_px.size();
        o_checked    <= checked_cnt;
    end

endmodule

/* test/tb.sv */
// Top of the region box blur testbench: clock, reset, stimulus, output back-pressure, verdict.
// Depends on rbb_pkg, rbb_ifs.sv, the block region_box_blur_3x3 and rbb_blur_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbb_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_DIM       = 64;
    localparam int RANDOM_ITEMS  = 380;
    localparam int QUIET_TAIL    = 120;
    localparam int HOLD_CYCLES   = 300;
    // Settling time after the last expected result; this leaves ample margin for the pipeline.
    localparam int SETTLE_CYCLES = 12;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(REG_REGION_RIGHT) + 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Random idling is switched per phase; the receiver follows the same switch.
    bit idle_en;
    // Raised by the stimulus, lowered by the receiver once its long hold is over.
    bit hold_request;

    int fail_count, pending, checked;
    int transfers_in, reg_writes, matrices_done, matrix_items;

    rbb_in_if  in_ch ();
    rbb_out_if out_ch ();
    rbb_cfg_if cfg_ch ();

    region_box_blur_3x3 #(
        .MAX_COLS(MAX_DIM),
        .MAX_ROWS(MAX_DIM)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    rbb_blur_checker #(
        .MAX_COLS(MAX_DIM),
        .MAX_ROWS(MAX_DIM)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .cfg_mon      (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Hard stop in case the block hangs; the slowest correct run needs well under 1 ms.
    initial begin
        #10ms;
        $display("region_box_blur_3x3 verification failed");
        $finish;
    end

    // Effective matrix dimension as the block uses it: clamped to [2, MAX_DIM].
    function automatic int eff_dim(input logic [CFG_DATA_W-1:0] raw);
        return (raw < 2) ? 2 : (raw > MAX_DIM) ? MAX_DIM : int'(raw);
    endfunction

    // Mostly full-range samples, with the two extremes and small values near zero
    // mixed in so that rounding ties and sign changes come up often.
    function automatic t_sample rand_sample();
        t_sample s;
        case ($urandom_range(0, 5))
            0:       s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       s = t_sample'($urandom_range(0, 16)) - 16'sd8;
            default: s = t_sample'($urandom);
        endcase
        return s;
    endfunction

    // One transfer on the input channel. Inputs change only at the falling edge;
    // an optional idle burst first drops valid.
    task automatic send_item(input t_opcode op, input t_sample smp);
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.opcode = op;
        in_ch.sample = smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        transfers_in++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        reg_writes++;
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] top, input logic [CFG_DATA_W-1:0] left,
                                input logic [CFG_DATA_W-1:0] bottom,
                                input logic [CFG_DATA_W-1:0] right);
        write_reg(REG_NUM_ROWS, rows);
        write_reg(REG_NUM_COLS, cols);
        write_reg(REG_REGION_TOP, top);
        write_reg(REG_REGION_LEFT, left);
        write_reg(REG_REGION_BOTTOM, bottom);
        write_reg(REG_REGION_RIGHT, right);
    endtask

    // Drops valid, then waits until every predicted result has been taken and the
    // pipeline has had time to finish any item that yields nothing.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A well-formed matrix in raster order followed by the flush ticks that drain it.
    // Noise is sprinkled in: flushes before the matrix is complete, elements while it
    // drains, and a stray flush after the final result. A broken matrix stops early
    // and is abandoned; the next register write restarts the block.
    task automatic feed_matrix(input int nr, input int nc, input bit broken);
        int k, stop_at;
        stop_at = broken ? $urandom_range(1, nr * nc - 1) : nr * nc;
        for (k = 0; k < stop_at; k++) begin
            if ($urandom_range(0, 24) == 0)
                send_item(OP_FLUSH, rand_sample());
            send_item(OP_ELEM, rand_sample());
        end
        matrix_items += stop_at;
        if (!broken) begin
            for (k = 0; k <= nc; k++) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(OP_ELEM, rand_sample());
                send_item(OP_FLUSH, rand_sample());
            end
            if ($urandom_range(0, 5) == 0)
                send_item(OP_FLUSH, rand_sample());
            matrix_items += nc + 1;
            matrices_done++;
        end
    endtask

    // Receiver side: random stall bursts, plus one long hold on request so that the
    // block backs up all the way to its input.
    initial begin : result_taker
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                out_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 16) - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial begin : stimulus
        int k, nr, nc, reps, base;
        logic [CFG_DATA_W-1:0] rows_raw, cols_raw, top_raw, left_raw, bot_raw, right_raw;
        t_sample corner_px [4];
        t_sample square_px [9];

        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_ELEM;
        in_ch.sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        idle_en      = 1'b1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Smallest matrix, reached by clamping row and column counts of 0 and 1. The top
        // and bottom region registers get bit 6 set so that masking brings them back to the full
        // matrix. Every pixel is a corner averaged over four values; the extremes sum
        // to a negative tie, which must round away from zero.
        corner_px = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
        program_regs(7'd0, 7'd1, 7'h40, 7'd0, 7'h7F, 7'd63);
        for (k = 0; k < 4; k++)
            send_item(OP_ELEM, corner_px[k]);
        for (k = 0; k < 3; k++)
            send_item(OP_FLUSH, 16'sh7FFF);
        // The matrix is complete, so this flush belongs to the next one and does nothing.
        send_item(OP_FLUSH, '0);
        wait_idle();

        // A 3x3 matrix whose region starts at (1,1) and reaches past the matrix. The
        // region top is written as 65 to check masking. This gives a nine-value
        // centre, six-value edges and a four-value corner. An element sent while the
        // matrix drains must be dropped.
        square_px = '{16'sd100, -16'sd7, 16'sd3, 16'sh7FFF, -16'sd100, 16'sd5,
                      16'sh8000, 16'sd2, 16'sd9};
        program_regs(7'd3, 7'd3, 7'd65, 7'd1, 7'd63, 7'd63);
        for (k = 0; k < 9; k++)
            send_item(OP_ELEM, square_px[k]);
        send_item(OP_FLUSH, '0);
        send_item(OP_ELEM, -16'sd1);
        for (k = 0; k < 3; k++)
            send_item(OP_FLUSH, '0);
        wait_idle();

        // Empty region: top below bottom, so everything passes through. Then a lone
        // element opens a matrix that the next register write abandons.
        program_regs(7'd2, 7'd2, 7'd1, 7'd0, 7'd0, 7'd63);
        feed_matrix(2, 2, 1'b0);
        send_item(OP_ELEM, 16'sh1234);
        wait_idle();

        // Long output hold with the sender running flat out, so the block fills and
        // stalls its input. A write to an unused index must change nothing.
        idle_en = 1'b0;
        program_regs(7'd6, 7'd40, 7'd1, 7'd2, 7'd4, 7'd37);
        write_reg(FIRST_UNUSED_IDX, 7'h2A);
        hold_request = 1'b1;
        feed_matrix(6, 40, 1'b0);
        wait_idle();

        // Random phases: a fresh setting, one or two matrices, then a pause until idle.
        base = matrix_items;
        while (matrix_items < base + RANDOM_ITEMS) begin
            idle_en = (matrix_items < base + RANDOM_ITEMS - QUIET_TAIL) &&
                      ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 15))
                0: begin
                    rows_raw = CFG_DATA_W'($urandom_range(0, 1));
                    cols_raw = CFG_DATA_W'($urandom_range(0, 1));
                end
                1: begin
                    rows_raw = CFG_DATA_W'($urandom_range(MAX_DIM, 127));
                    cols_raw = CFG_DATA_W'($urandom_range(2, 3));
                end
                2: begin
                    rows_raw = CFG_DATA_W'($urandom_range(2, 3));
                    cols_raw = CFG_DATA_W'($urandom_range(MAX_DIM, 127));
                end
                default: begin
                    rows_raw = CFG_DATA_W'($urandom_range(2, 8));
                    cols_raw = CFG_DATA_W'($urandom_range(2, 10));
                end
            endcase
            nr = eff_dim(rows_raw);
            nc = eff_dim(cols_raw);
            case ($urandom_range(0, 4))
                0: begin
                    // Whole matrix, with bit 6 toggled at random to exercise masking.
                    top_raw   = 7'($urandom_range(0, 1) << 6);
                    left_raw  = 7'($urandom_range(0, 1) << 6);
                    bot_raw   = 7'd63 | 7'($urandom_range(0, 1) << 6);
                    right_raw = 7'd63 | 7'($urandom_range(0, 1) << 6);
                end
                1: begin
                    // Empty in rows or in columns.
                    top_raw   = CFG_DATA_W'($urandom_range(1, 63));
                    bot_raw   = CFG_DATA_W'($urandom_range(0, top_raw - 1));
                    left_raw  = CFG_DATA_W'($urandom_range(0, 63));
                    right_raw = CFG_DATA_W'($urandom_range(0, 63));
                    if ($urandom_range(0, 1)) begin
                        {top_raw, left_raw}  = {left_raw, top_raw};
                        {bot_raw, right_raw} = {right_raw, bot_raw};
                    end
                end
                2: begin
                    top_raw   = CFG_DATA_W'($urandom_range(0, nr - 1));
                    bot_raw   = CFG_DATA_W'($urandom_range(top_raw, nr - 1));
                    left_raw  = CFG_DATA_W'($urandom_range(0, nc - 1));
                    right_raw = CFG_DATA_W'($urandom_range(left_raw, nc - 1));
                end
                3: begin
                    top_raw   = CFG_DATA_W'($urandom_range(0, 127));
                    bot_raw   = CFG_DATA_W'($urandom_range(0, 127));
                    left_raw  = CFG_DATA_W'($urandom_range(0, 127));
                    right_raw = CFG_DATA_W'($urandom_range(0, 127));
                end
                default: begin
                    // Starts inside the matrix and reaches to or past its bottom right.
                    top_raw   = CFG_DATA_W'($urandom_range(0, nr - 1));
                    bot_raw   = CFG_DATA_W'($urandom_range(nr - 1, 63));
                    left_raw  = CFG_DATA_W'($urandom_range(0, nc - 1));
                    right_raw = CFG_DATA_W'($urandom_range(nc - 1, 63));
                end
            endcase
            program_regs(rows_raw, cols_raw, top_raw, left_raw, bot_raw, right_raw);
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            reps = ($urandom_range(0, 2) == 0) ? 2 : 1;
            for (k = 0; k < reps; k++)
                feed_matrix(nr, nc, (k == reps - 1) && ($urandom_range(0, 9) == 0));
            wait_idle();
        end

        // wait_idle has already drained every expected result; give stray results a
        // little longer to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d complete matrices, %0d register writes and %0d input transfers,",
                 matrices_done, reg_writes, transfers_in);
        $display("with %0d results checked, random stalls on both sides and a %0d-cycle output hold.",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("region_box_blur_3x3 verification clean");
        end else begin
            $display("region_box_blur_3x3 verification failed");
        end
        $finish;
    end

endmodule
